// File: src/bums_pkg.sv
// ============================================================================
// bums_pkg
// Shared constants and types of the sorter core and its cells.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bums_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic drain;
        logic occupied;
        logic at_fill;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: src/bums_cell.sv
// ============================================================================
// bums_cell
// One slot of the sorting chain. Inserts shift larger values to the right,
// and draining shifts every value one slot to the left.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bums_cell (
    input  wire logic                                 i_clk,
    input  wire bums_pkg::t_cell_ctrl                 i_ctrl,
    input  wire logic signed [bums_pkg::DATA_W-1:0]   i_new_value,
    input  wire logic signed [bums_pkg::DATA_W-1:0]   i_left_value,
    input  wire logic                                 i_left_le,
    input  wire logic signed [bums_pkg::DATA_W-1:0]   i_right_value,
    output logic signed [bums_pkg::DATA_W-1:0]        o_value,
    output logic                                      o_le
);

    logic signed [bums_pkg::DATA_W-1:0] r_value;
    logic signed [bums_pkg::DATA_W-1:0] n_value;

    assign o_le    = i_ctrl.occupied && (r_value <= i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.drain) begin
            n_value = i_right_value;
        end else if (i_ctrl.insert && (i_ctrl.at_fill || (i_ctrl.occupied && !o_le))) begin
            n_value = i_left_le ? i_new_value : i_left_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// File: src/bottom_up_merge_sorter_core.sv
// ============================================================================
// bottom_up_merge_sorter_core
// Collects a set of signed values and returns them in ascending order.
// ============================================================================
// Loading accepts one request per cycle; each value is placed in order at once.
// The first result is offered in the cycle after the final request is taken.
// Results then leave at one per cycle while i_ready is high.
// No request is taken while a set is being emitted.
// Reset clears the state, the fill count and the overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module bottom_up_merge_sorter_core #(
    parameter int MAX_ELEMENTS = bums_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [bums_pkg::DATA_W-1:0] i_sample_value,
    input  wire logic                               i_final_item,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [bums_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                                    o_run_end,
    output logic                                    o_dropped_any
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    bums_pkg::t_state r_state;
    bums_pkg::t_state n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_overflow;
    logic             n_overflow;
    logic             w_insert;
    logic             w_drain;

    logic signed [bums_pkg::DATA_W-1:0] w_value [MAX_ELEMENTS];
    logic                               w_le    [MAX_ELEMENTS];
    bums_pkg::t_cell_ctrl               w_ctrl  [MAX_ELEMENTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bums_pkg::ST_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        o_ready    = 1'b0;
        o_valid    = 1'b0;
        w_insert   = 1'b0;
        w_drain    = 1'b0;
        case (r_state)
            bums_pkg::ST_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (r_count < CNT_W'(MAX_ELEMENTS)) begin
                        w_insert = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_final_item) begin
                        n_state = bums_pkg::ST_EMIT;
                    end
                end
            end
            bums_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    w_drain = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_overflow = 1'b0;
                        n_state    = bums_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = bums_pkg::ST_LOAD;
            end
        endcase
    end

    assign o_sorted_value = w_value[0];
    assign o_run_end      = (r_count == CNT_W'(1));
    assign o_dropped_any  = r_overflow;

    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        logic signed [bums_pkg::DATA_W-1:0] w_left;
        logic signed [bums_pkg::DATA_W-1:0] w_right;
        logic                               w_left_le;

        assign w_ctrl[i].insert   = w_insert;
        assign w_ctrl[i].drain    = w_drain;
        assign w_ctrl[i].occupied = (CNT_W'(i) < r_count);
        assign w_ctrl[i].at_fill  = (CNT_W'(i) == r_count);

        if (i == 0) begin : g_first
            assign w_left    = i_sample_value;
            assign w_left_le = 1'b1;
        end else begin : g_inner
            assign w_left    = w_value[i-1];
            assign w_left_le = w_le[i-1];
        end

        if (i == MAX_ELEMENTS - 1) begin : g_last
            assign w_right = w_value[i];
        end else begin : g_body
            assign w_right = w_value[i+1];
        end

        bums_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl[i]),
            .i_new_value   (i_sample_value),
            .i_left_value  (w_left),
            .i_left_le     (w_left_le),
            .i_right_value (w_right),
            .o_value       (w_value[i]),
            .o_le          (w_le[i])
        );
    end

endmodule

`default_nettype wire

// File: src/bums_checker.sv
// ============================================================================
// bums_checker
// Port-level checks of the sorter core, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bums_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_ready,
    input wire logic                               i_final_item,
    input wire logic                               o_valid,
    input wire logic                               i_ready,
    input wire logic signed [bums_pkg::DATA_W-1:0] o_sorted_value,
    input wire logic                               o_run_end,
    input wire logic                               o_dropped_any
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("Input taken while a set is being emitted.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sorted_value)))
        else $error("Stalled result changed.");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_run_end) |=>
            (o_valid && $stable(o_dropped_any) &&
             ($signed(o_sorted_value) >= $signed($past(o_sorted_value)))))
        else $error("Results out of order or set ended early.");

    a_final_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_final_item) |=> o_valid)
        else $error("No result after the final request.");

    a_end_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_run_end) |=> (o_ready && !o_valid))
        else $error("Block not ready for a new set after the last result.");

endmodule

bind bottom_up_merge_sorter_core bums_checker u_bums_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_final_item   (i_final_item),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sorted_value (o_sorted_value),
    .o_run_end      (o_run_end),
    .o_dropped_any  (o_dropped_any)
);

`default_nettype wire
